// ----- hw/rtl/qte_pkg.sv -----
package qte_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // internal formats
  localparam int QW = 23;   // component, Q2.20
  localparam int PW = 46;   // product, Q.40
  localparam int TW = 48;   // term, Q.40
  localparam int VW = 50;   // CORDIC vector legs
  localparam int ZW = 34;   // angle accumulator, 2^32 per turn
  localparam int SW = 32;   // arcsine leg, Q.30
  localparam int RW = 61;   // root and remainder
  localparam int SQRT_STEPS = 31;
  localparam int NLANE = 3;

  localparam logic signed [TW-1:0] ONE       = TW'(1) <<< 40;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) <<< 31;
  localparam logic [RW-1:0]        SQ_LIM    = RW'(1) << 60;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic                 valid;
    lane_t                roll;
    lane_t                yaw;
    logic signed [SW-1:0] s;
    logic                 clamp;
    logic                 cneg;
    logic [RW-1:0]        rem;
    logic [RW-1:0]        root;
  } sqrt_word_t;

  typedef struct packed {
    logic                   valid;
    lane_t [NLANE-1:0]      lane;
    logic                   clamp;
    logic                   cneg;
  } cordic_word_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] k);
    logic signed [ZW-1:0] a;
    unique case (k)
      5'd0:  a = 34'sh020000000;
      5'd1:  a = 34'sh012E4051E;
      5'd2:  a = 34'sh009FB385B;
      5'd3:  a = 34'sh0051111D4;
      5'd4:  a = 34'sh0028B0D43;
      5'd5:  a = 34'sh00145D7E1;
      5'd6:  a = 34'sh000A2F61E;
      5'd7:  a = 34'sh000517C55;
      5'd8:  a = 34'sh00028BE53;
      5'd9:  a = 34'sh000145F2F;
      5'd10: a = 34'sh0000A2F98;
      5'd11: a = 34'sh0000517CC;
      5'd12: a = 34'sh000028BE6;
      5'd13: a = 34'sh0000145F3;
      5'd14: a = 34'sh00000A2FA;
      5'd15: a = 34'sh00000517D;
      5'd16: a = 34'sh0000028BE;
      5'd17: a = 34'sh00000145F;
      5'd18: a = 34'sh000000A30;
      5'd19: a = 34'sh000000518;
      5'd20: a = 34'sh00000028C;
      5'd21: a = 34'sh000000146;
      5'd22: a = 34'sh0000000A3;
      5'd23: a = 34'sh000000051;
      5'd24: a = 34'sh000000029;
      5'd25: a = 34'sh000000014;
      5'd26: a = 34'sh00000000A;
      5'd27: a = 34'sh000000005;
      5'd28: a = 34'sh000000003;
      5'd29: a = 34'sh000000001;
      5'd30: a = 34'sh000000001;
      5'd31: a = 34'sh000000000;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Pipeline: four front stages, 31 square-root cells, one CORDIC entry stage,
//   CORDIC_STEPS vectoring cells and one output register.
// Throughput: one word per cycle; the whole chain advances whenever the output
//   register is empty or being taken.
// Reset (rst, synchronous, active high) clears all stage valid flags.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int IN_W        = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W       = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w from bit 0, zero padded
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle from bit 0, zero padded
  output logic [OUT_W-1:0]    m_axis_tdata,
  // pitch_clamped
  output logic                m_axis_tuser
);

  localparam int SHR   = 32 - DATA_WIDTH;
  localparam logic signed [ZW-1:0] RND     = (ZW'(2) << SHR) >>> 2;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (DATA_WIDTH - 2);

  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  logic [3:0][DATA_WIDTH-1:0] quat;
  assign quat = s_axis_tdata[4*DATA_WIDTH-1:0];

  sqrt_word_t sw [SQRT_STEPS+1];

  qte_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_axis_tvalid),
    .quat     (quat),
    .out_word (sw[0])
  );

  genvar i;
  generate
    for (i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      qte_sqrt_cell #(.BIT_POS(SQRT_STEPS - 1 - i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ce       (ce),
        .in_word  (sw[i]),
        .out_word (sw[i+1])
      );
    end
  endgenerate

  cordic_word_t cw [CORDIC_STEPS+1];
  cordic_word_t cw_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_head.valid <= 1'b0;
    end else if (ce) begin
      cw_head.valid <= sw[SQRT_STEPS].valid;
    end
    if (ce) begin
      cw_head.lane[LANE_ROLL]    <= sw[SQRT_STEPS].roll;
      cw_head.lane[LANE_YAW]     <= sw[SQRT_STEPS].yaw;
      cw_head.lane[LANE_PITCH].x <= VW'(sw[SQRT_STEPS].root);
      cw_head.lane[LANE_PITCH].y <= VW'(sw[SQRT_STEPS].s);
      cw_head.lane[LANE_PITCH].z <= '0;
      cw_head.clamp              <= sw[SQRT_STEPS].clamp;
      cw_head.cneg               <= sw[SQRT_STEPS].cneg;
    end
  end

  assign cw[0] = cw_head;

  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      qte_cordic_cell #(.STEP(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ce       (ce),
        .in_word  (cw[i]),
        .out_word (cw[i+1])
      );
    end
  endgenerate

  // round half up to output angle units
  logic signed [ZW-1:0] full [NLANE];
  logic signed [ZW-1:0] pitch_full;
  cordic_word_t         last;

  assign last = cw[CORDIC_STEPS];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      full[l] = (last.lane[l].z + RND) >>> SHR;
    end
    if (last.clamp) begin
      pitch_full = last.cneg ? -QUARTER : QUARTER;
    end else if (full[LANE_PITCH] > QUARTER) begin
      pitch_full = QUARTER;
    end else if (full[LANE_PITCH] < -QUARTER) begin
      pitch_full = -QUARTER;
    end else begin
      pitch_full = full[LANE_PITCH];
    end
  end

  logic [DATA_WIDTH-1:0] roll_angle, pitch_angle, yaw_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= last.valid;
    end
    if (ce) begin
      roll_angle   <= full[LANE_ROLL][DATA_WIDTH-1:0];
      pitch_angle  <= pitch_full[DATA_WIDTH-1:0];
      yaw_angle    <= full[LANE_YAW][DATA_WIDTH-1:0];
      m_axis_tuser <= last.clamp;
    end
  end

  assign m_axis_tdata = OUT_W'({yaw_angle, pitch_angle, roll_angle});

`ifndef NO_ASSERTIONS
  logic signed [DATA_WIDTH-1:0] pitch_s;
  assign pitch_s = $signed(pitch_angle);

  a_clamp_mag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (ZW'(pitch_s) == QUARTER) || (ZW'(pitch_s) == -QUARTER))
    else $error("clamped pitch not at a quarter turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ZW'(pitch_s) <= QUARTER) && (ZW'(pitch_s) >= -QUARTER))
    else $error("pitch out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(cw[0].valid) && $stable(sw[0].valid))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ----- hw/rtl/qte_front.sv -----
module qte_front import qte_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [3:0][DATA_WIDTH-1:0] quat,     // x, y, z, w from index 0
  output sqrt_word_t                 out_word
);

  logic signed [QW-1:0] q20 [4];

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_conv
      if (DATA_WIDTH <= 22) begin : g_up
        assign q20[g] = QW'($signed(quat[g])) <<< (22 - DATA_WIDTH);
      end else begin : g_down
        assign q20[g] = QW'($signed(quat[g]) >>> (DATA_WIDTH - 22));
      end
    end
  endgenerate

  // stage 1: products
  logic                 v1;
  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
    if (ce) begin
      p_wx <= q20[3] * q20[0];
      p_yz <= q20[1] * q20[2];
      p_xx <= q20[0] * q20[0];
      p_yy <= q20[1] * q20[1];
      p_wy <= q20[3] * q20[1];
      p_zx <= q20[2] * q20[0];
      p_wz <= q20[3] * q20[2];
      p_xy <= q20[0] * q20[1];
      p_zz <= q20[2] * q20[2];
    end
  end

  // stage 2: terms
  logic                 v2;
  logic signed [TW-1:0] sinr, cosr, sinp, siny, cosy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      sinr <= (TW'(p_wx) + TW'(p_yz)) <<< 1;
      cosr <= ONE - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
      sinp <= (TW'(p_wy) - TW'(p_zx)) <<< 1;
      siny <= (TW'(p_wz) + TW'(p_xy)) <<< 1;
      cosy <= ONE - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
    end
  end

  // stage 3: half-plane fold, arcsine leg
  logic                 v3;
  lane_t                roll3, yaw3;
  logic signed [SW-1:0] s3;
  logic                 clamp3, cneg3;
  logic [SW-2:0]        s2_3;

  lane_t                roll_c, yaw_c;
  logic                 clamp_c;
  logic signed [TW-1:0] sinp_sh;
  logic signed [SW-1:0] s_c;

  always_comb begin
    roll_c.x = VW'(cosr);
    roll_c.y = VW'(sinr);
    roll_c.z = '0;
    if (cosr < 0) begin
      roll_c.x = -VW'(cosr);
      roll_c.y = -VW'(sinr);
      roll_c.z = HALF_TURN;
    end
    yaw_c.x = VW'(cosy);
    yaw_c.y = VW'(siny);
    yaw_c.z = '0;
    if (cosy < 0) begin
      yaw_c.x = -VW'(cosy);
      yaw_c.y = -VW'(siny);
      yaw_c.z = HALF_TURN;
    end
    clamp_c = (sinp >= ONE) || (sinp <= -ONE);
    sinp_sh = sinp >>> 10;
    s_c     = clamp_c ? '0 : SW'(sinp_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
    if (ce) begin
      roll3  <= roll_c;
      yaw3   <= yaw_c;
      s3     <= s_c;
      s2_3   <= s_c[SW-1] ? (SW-1)'(-s_c) : s_c[SW-2:0];
      clamp3 <= clamp_c;
      cneg3  <= sinp[TW-1];
    end
  end

  // stage 4: radicand for the cosine leg
  logic [2*(SW-1)-1:0] sq;
  assign sq = s2_3 * s2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (ce) begin
      out_word.valid <= v3;
    end
    if (ce) begin
      out_word.roll  <= roll3;
      out_word.yaw   <= yaw3;
      out_word.s     <= s3;
      out_word.clamp <= clamp3;
      out_word.cneg  <= cneg3;
      out_word.rem   <= SQ_LIM - sq[RW-1:0];
      out_word.root  <= '0;
    end
  end

endmodule

// ----- hw/rtl/qte_sqrt_cell.sv -----
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int BIT_POS = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       ce,
  input  sqrt_word_t in_word,
  output sqrt_word_t out_word
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * BIT_POS);

  sqrt_word_t nxt;
  logic [RW:0] trial;

  always_comb begin
    nxt   = in_word;
    trial = {1'b0, in_word.root} + {1'b0, BIT};
    if ({1'b0, in_word.rem} >= trial) begin
      nxt.rem  = in_word.rem - trial[RW-1:0];
      nxt.root = (in_word.root >> 1) + BIT;
    end else begin
      nxt.root = in_word.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (ce) begin
      out_word <= nxt;
    end
  end

endmodule

// ----- hw/rtl/qte_cordic_cell.sv -----
module qte_cordic_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         ce,
  input  cordic_word_t in_word,
  output cordic_word_t out_word
);

  localparam logic [4:0] IDX = STEP[4:0];
  localparam logic signed [ZW-1:0] ANG = atan_entry(IDX);

  cordic_word_t nxt;
  logic signed [VW-1:0] xs [NLANE];
  logic signed [VW-1:0] ys [NLANE];

  always_comb begin
    nxt = in_word;
    for (int l = 0; l < NLANE; l++) begin
      xs[l] = in_word.lane[l].x >>> IDX;
      ys[l] = in_word.lane[l].y >>> IDX;
      // a lane already on the axis stays put
      if (in_word.lane[l].y != '0) begin
        if (!in_word.lane[l].y[VW-1]) begin
          nxt.lane[l].x = in_word.lane[l].x + ys[l];
          nxt.lane[l].y = in_word.lane[l].y - xs[l];
          nxt.lane[l].z = in_word.lane[l].z + ANG;
        end else begin
          nxt.lane[l].x = in_word.lane[l].x - ys[l];
          nxt.lane[l].y = in_word.lane[l].y + xs[l];
          nxt.lane[l].z = in_word.lane[l].z - ANG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (ce) begin
      out_word <= nxt;
    end
  end

endmodule

// ----- sim/quaternion_to_euler_angles_test.sv -----
`timescale 1ns / 1ps

module quaternion_to_euler_angles_test;
  import qte_pkg::*;

  localparam int DW     = 16;
  localparam int STEPS  = 16;
  localparam int IN_W   = 4 * DW;
  localparam int OUT_W  = 3 * DW;
  localparam int LAT    = 37 + STEPS;
  localparam int N_RAND = 750;
  localparam int HOLD_AT = 300;
  localparam longint LIMIT = 400000;

  typedef struct {
    logic signed [DW-1:0] roll;
    logic signed [DW-1:0] pitch;
    logic signed [DW-1:0] yaw;
    logic                 clamped;
  } euler_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;       // roll, pitch, yaw
  logic m_axis_tuser;                   // pitch_clamped

  logic [IN_W-1:0] quat_queue[$];
  euler_t angle_queue[$];
  int words_sent = 0;
  int errors = 0;
  bit stim_done = 0;
  longint cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [15:0] stall_pattern = 16'hffff;

  quaternion_to_euler_angles #(.DATA_WIDTH(DW), .CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, 2^32 units per turn
  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(HALF_TURN);
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y == 0) break;
      xs = x >>> (i & 31);
      ys = y >>> (i & 31);
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(atan_entry(5'(i)));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(atan_entry(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint to_binary_angle(longint z);
    return (z + (longint'(1) << (31 - DW))) >>> (32 - DW);
  endfunction

  function automatic euler_t predict_angles(logic [IN_W-1:0] w);
    longint qx, qy, qz, qw, one, quarter, sinr, cosr, sinp, siny, cosy, s, p;
    longint unsigned sq, lim;
    euler_t e;
    qx = longint'($signed(w[0*DW +: DW])) * 64;
    qy = longint'($signed(w[1*DW +: DW])) * 64;
    qz = longint'($signed(w[2*DW +: DW])) * 64;
    qw = longint'($signed(w[3*DW +: DW])) * 64;
    one = longint'(1) << 40;
    quarter = longint'(1) << (DW - 2);
    sinr = 2 * (qw * qx + qy * qz);
    cosr = one - 2 * (qx * qx + qy * qy);
    sinp = 2 * (qw * qy - qz * qx);
    siny = 2 * (qw * qz + qx * qy);
    cosy = one - 2 * (qy * qy + qz * qz);
    e.clamped = 0;
    if (sinp >= one) begin
      p = quarter;
      e.clamped = 1;
    end else if (sinp <= -one) begin
      p = -quarter;
      e.clamped = 1;
    end else begin
      s = sinp >>> 10;
      sq = longint'(s < 0 ? -s : s) * longint'(s < 0 ? -s : s);
      lim = 64'd1 << 60;
      p = to_binary_angle(vector_angle(s, longint'(int_sqrt(sq >= lim ? 0 : lim - sq))));
      if (p > quarter) p = quarter;
      if (p < -quarter) p = -quarter;
    end
    e.roll = DW'(to_binary_angle(vector_angle(sinr, cosr)));
    e.pitch = DW'(p);
    e.yaw = DW'(to_binary_angle(vector_angle(siny, cosy)));
    return e;
  endfunction

  function automatic logic [IN_W-1:0] pack_quat(int x, int y, int z, int w);
    return {DW'(w), DW'(z), DW'(y), DW'(x)};
  endfunction

  // sender: bursts and gaps; one pause to drain the pipe
  always @(posedge clk) begin
    bit fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (fire) begin
        angle_queue.push_back(predict_angles(s_axis_tdata));
        void'(quat_queue.pop_front());
        words_sent++;
        if (burst_left > 0) burst_left--;
      end
      if (!s_axis_tvalid || fire) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 0;
        end else if (quat_queue.size() == 0 ||
                     (words_sent == HOLD_AT && angle_queue.size() != 0)) begin
          s_axis_tvalid <= 0;
        end else begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= quat_queue[0];
        end
      end
    end
  end

  // receiver: checks each word; ready follows a random stall pattern
  always @(posedge clk) begin
    euler_t e;
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (angle_queue.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        e = angle_queue.pop_front();
        if (m_axis_tdata[0*DW +: DW] !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, $signed(m_axis_tdata[0*DW +: DW]));
          errors++;
        end
        if (m_axis_tdata[1*DW +: DW] !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, $signed(m_axis_tdata[1*DW +: DW]));
          errors++;
        end
        if (m_axis_tdata[2*DW +: DW] !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, $signed(m_axis_tdata[2*DW +: DW]));
          errors++;
        end
        if (m_axis_tuser !== e.clamped) begin
          $error("pitch_clamped exp %0d got %0d", e.clamped, m_axis_tuser);
          errors++;
        end
      end
    end
    if (cycles % 16 == 0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
    m_axis_tready <= stall_pattern[cycles % 16];
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("quaternion_to_euler_angles verification failed");
      $finish;
    end
  end

  initial begin
    int a, b;
    // zero, identity, extremes
    quat_queue.push_back(pack_quat(0, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 16384));
    quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
    // roll or yaw of pi (left half plane, zero or near-zero sine)
    quat_queue.push_back(pack_quat(16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 16384, 0));
    quat_queue.push_back(pack_quat(16384, 0, 0, 1));
    quat_queue.push_back(pack_quat(16384, 0, 0, -1));
    // pitch saturation, both signs, and just below
    quat_queue.push_back(pack_quat(0, 11586, 0, 11586));
    quat_queue.push_back(pack_quat(0, -11586, 0, 11586));
    quat_queue.push_back(pack_quat(0, 11585, 0, 11585));
    quat_queue.push_back(pack_quat(0, 11585, 0, -11585));
    quat_queue.push_back(pack_quat(0, 16384, 0, 16384));
    quat_queue.push_back(pack_quat(11585, 0, -11586, 0));
    quat_queue.push_back(pack_quat(1, -1, 1, -1));
    quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
    quat_queue.push_back(pack_quat(0, 0, 11585, 11585));
    quat_queue.push_back(pack_quat(11585, 0, 0, -11585));
    for (int i = 0; i < N_RAND; i++) begin
      case ($urandom_range(0, 3))
        0: quat_queue.push_back(IN_W'({$urandom, $urandom}));
        1: begin  // near gimbal lock
          a = $urandom_range(11000, 12000);
          b = $urandom_range(0, 1) ? a : -a;
          quat_queue.push_back(pack_quat($urandom_range(0, 200) - 100, b,
                                         $urandom_range(0, 200) - 100, a));
        end
        default: quat_queue.push_back(pack_quat(int'($urandom_range(0, 32768)) - 16384,
                                                int'($urandom_range(0, 32768)) - 16384,
                                                int'($urandom_range(0, 32768)) - 16384,
                                                int'($urandom_range(0, 32768)) - 16384));
      endcase
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    wait (quat_queue.size() == 0 && !s_axis_tvalid);
    wait (angle_queue.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0)
      $display("quaternion_to_euler_angles verification clean");
    else
      $display("quaternion_to_euler_angles verification failed");
    $finish;
  end

endmodule
